// ===== rtl/rc5_pkg.sv =====
`default_nettype none
package rc5_pkg;

  localparam int ROUNDS      = 12;
  localparam int KEY_BYTES   = 16;
  localparam int WORD_W      = 32;
  localparam int TABLE_ROWS  = ROUNDS + 1;
  localparam int TABLE_WORDS = 2 * TABLE_ROWS;
  localparam int KEY_WORDS   = (KEY_BYTES + 3) / 4;
  localparam int MIX_STEPS   = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);

  localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int IDX_W = ROW_W + 1;
  localparam int KW_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int SC_W  = $clog2(MIX_STEPS);

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int DATA_W    = 2 * WORD_W;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [WORD_W-1:0] MAGIC_P = 32'hB7E1_5163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9E37_79B9;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SETUP,
    DP_SEED,
    DP_MIX,
    DP_LOAD,
    DP_ENC_INIT,
    DP_ENC_RND,
    DP_DEC_RND,
    DP_DEC_FINAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic               out_load;
    logic [IDX_W-1:0]   widx;
    logic [KW_W-1:0]    kidx;
    logic [ROW_W-1:0]   rd_row;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/rc5_ram.sv =====
`default_nettype none
module rc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rc5_ctrl.sv =====
`default_nettype none
module rc5_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire logic             cfg_we,
  output rc5_pkg::dp_cmd_t      cmd
);
  import rc5_pkg::*;

  typedef enum logic [2:0] {
    ST_SETUP,
    ST_SEED,
    ST_MIX_PRE,
    ST_MIX,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [KW_W-1:0]  kidx, kidx_next;
  logic [SC_W-1:0]  step, step_next;
  logic [ROW_W-1:0] row, row_next;
  logic             dec, dec_next;
  logic             m_tvalid_next;
  logic             out_free;
  logic             accept;
  logic             last;
  logic [IDX_W-1:0] idx_inc;

  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign idx_inc  = (idx == IDX_W'(TABLE_WORDS - 1)) ? '0 : idx + 1'b1;
  assign last     = dec ? (row == '0) : (row == ROW_W'(ROUNDS));

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    kidx_next     = kidx;
    step_next     = step;
    row_next      = row;
    dec_next      = dec;
    m_tvalid_next = m_tvalid;
    s_tready      = 1'b0;
    cmd           = '{op: DP_NOP, out_load: 1'b0, widx: idx, kidx: kidx, rd_row: '0};

    if (m_tvalid && m_tready) begin
      m_tvalid_next = 1'b0;
    end

    unique case (state)
      ST_SETUP: begin
        cmd.op     = DP_SETUP;
        idx_next   = '0;
        state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.op   = DP_SEED;
        idx_next = idx_inc;
        if (idx == IDX_W'(TABLE_WORDS - 1)) begin
          state_next = ST_MIX_PRE;
        end
      end
      ST_MIX_PRE: begin
        cmd.rd_row = idx[IDX_W-1:1];
        step_next  = '0;
        kidx_next  = '0;
        state_next = ST_MIX;
      end
      ST_MIX: begin
        cmd.op     = DP_MIX;
        cmd.rd_row = idx_inc[IDX_W-1:1];
        idx_next   = idx_inc;
        kidx_next  = (kidx == KW_W'(KEY_WORDS - 1)) ? '0 : kidx + 1'b1;
        step_next  = step + 1'b1;
        if (step == SC_W'(MIX_STEPS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          cmd.op     = DP_LOAD;
          dec_next   = (s_tuser == OP_DECRYPT);
          row_next   = (s_tuser == OP_DECRYPT) ? ROW_W'(ROUNDS) : '0;
          cmd.rd_row = row_next;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (dec) begin
          cmd.op     = (row == '0) ? DP_DEC_FINAL : DP_DEC_RND;
          cmd.rd_row = last ? '0 : row - 1'b1;
          row_next   = last ? row : row - 1'b1;
        end else begin
          cmd.op     = (row == '0) ? DP_ENC_INIT : DP_ENC_RND;
          cmd.rd_row = last ? '0 : row + 1'b1;
          row_next   = last ? row : row + 1'b1;
        end
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        s_tready = out_free;
        if (out_free) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
          if (accept) begin
            cmd.op     = DP_LOAD;
            dec_next   = (s_tuser == OP_DECRYPT);
            row_next   = (s_tuser == OP_DECRYPT) ? ROW_W'(ROUNDS) : '0;
            cmd.rd_row = row_next;
            state_next = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_SETUP;
      end
    endcase

    if (cfg_we) begin
      state_next = ST_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SETUP;
      m_tvalid <= 1'b0;
      idx      <= '0;
      kidx     <= '0;
      step     <= '0;
      row      <= '0;
      dec      <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
      idx      <= idx_next;
      kidx     <= kidx_next;
      step     <= step_next;
      row      <= row_next;
      dec      <= dec_next;
    end
  end

  a_no_accept_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input accepted right after a key write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second block accepted while a block is in flight");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while held");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (row <= ROW_W'(ROUNDS)))
    else $error("round row out of range");

endmodule
`default_nettype wire

// ===== rtl/rc5_dp.sv =====
`default_nettype none
module rc5_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [rc5_pkg::DATA_W-1:0]      s_tdata,
  output logic      [rc5_pkg::DATA_W-1:0]      m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [rc5_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rc5_pkg::CFG_W-1:0]       cfg_data,
  input  wire rc5_pkg::dp_cmd_t                cmd
);
  import rc5_pkg::*;

  localparam logic [2*CFG_W-1:0] KEY_MASK = {(2 * CFG_W){1'b1}} >> (2 * CFG_W - 8 * KEY_BYTES);

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input logic [4:0] n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input logic [4:0] n);
    logic [2*WORD_W-1:0] t;
    t = {v, v} >> n;
    return t[WORD_W-1:0];
  endfunction

  logic [CFG_W-1:0]   key_low;
  logic [CFG_W-1:0]   key_high;
  logic [2*CFG_W-1:0] key_full;
  logic [WORD_W-1:0]  kw [KEY_WORDS];
  logic [WORD_W-1:0]  sa, sb, seed_acc;
  logic [WORD_W-1:0]  wa, wb;
  logic [WORD_W-1:0]  out_a, out_b;

  logic [WORD_W-1:0]  rd_even, rd_odd;
  logic [WORD_W-1:0]  s_cur;
  logic [WORD_W-1:0]  mix_a, mix_ab, mix_b;
  logic [WORD_W-1:0]  enc_a, enc_b, dec_a, dec_b;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_we, we_even, we_odd;

  assign key_full = {key_high, key_low} & KEY_MASK;

  assign s_cur  = cmd.widx[0] ? rd_odd : rd_even;
  assign mix_a  = rotl(s_cur + sa + sb, 5'd3);
  assign mix_ab = mix_a + sb;
  assign mix_b  = rotl(kw[cmd.kidx] + mix_ab, mix_ab[4:0]);

  assign enc_a = rotl(wa ^ wb, wb[4:0]) + rd_even;
  assign enc_b = rotl(wb ^ enc_a, enc_a[4:0]) + rd_odd;
  assign dec_b = rotr(wb - rd_odd, wa[4:0]) ^ wa;
  assign dec_a = rotr(wa - rd_even, dec_b[4:0]) ^ dec_b;

  assign ram_we    = (cmd.op == DP_SEED) || (cmd.op == DP_MIX);
  assign ram_wdata = (cmd.op == DP_SEED) ? seed_acc : mix_a;
  assign we_even   = ram_we && !cmd.widx[0];
  assign we_odd    = ram_we && cmd.widx[0];

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ROWS)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (cmd.widx[IDX_W-1:1]),
    .wdata (ram_wdata),
    .raddr (cmd.rd_row),
    .rdata (rd_even)
  );

  rc5_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_ROWS)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (cmd.widx[IDX_W-1:1]),
    .wdata (ram_wdata),
    .raddr (cmd.rd_row),
    .rdata (rd_odd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_SETUP: begin
        sa       <= '0;
        sb       <= '0;
        seed_acc <= MAGIC_P;
        for (int k = 0; k < KEY_WORDS; k++) begin
          kw[k] <= key_full[k*WORD_W +: WORD_W];
        end
      end
      DP_SEED: begin
        seed_acc <= seed_acc + MAGIC_Q;
      end
      DP_MIX: begin
        sa           <= mix_a;
        sb           <= mix_b;
        kw[cmd.kidx] <= mix_b;
      end
      DP_LOAD: begin
        wa <= s_tdata[WORD_W-1:0];
        wb <= s_tdata[DATA_W-1:WORD_W];
      end
      DP_ENC_INIT: begin
        wa <= wa + rd_even;
        wb <= wb + rd_odd;
      end
      DP_ENC_RND: begin
        wa <= enc_a;
        wb <= enc_b;
      end
      DP_DEC_RND: begin
        wa <= dec_a;
        wb <= dec_b;
      end
      DP_DEC_FINAL: begin
        wa <= wa - rd_even;
        wb <= wb - rd_odd;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_a <= wa;
      out_b <= wb;
    end
  end

  assign m_tdata = {out_b, out_a};

endmodule
`default_nettype wire

// ===== rtl/rc5_block_cipher_top.sv =====
// RC5-32/12/16 block cipher, ECB, one 64-bit block per transfer.
// Input stream: s_tdata carries the block words, s_tuser selects encrypt (0)
// or decrypt (1). Output stream: m_tdata carries the result words.
// Key: two 64-bit registers written through cfg_we/cfg_idx/cfg_data
// (index 0 key bytes 0-7, index 1 key bytes 8-15, byte 0 in the low bits).
// Every key write, and reset, starts the key schedule: a setup step,
// seeding of the 26-word subkey table, a prefetch step and 78 mixing
// steps, with s_tready low until it completes.
// Reset clears both key registers, so the all-zero key is scheduled.
// A block is loaded at its input transfer, walks the 13 subkey rows on the
// round unit (one full round per cycle, subkey pairs read from two 13-word
// RAMs), then is copied into the output register once that register is
// free, and m_tvalid rises as it is registered. No block is taken while
// one is on the round unit; the next is taken in the cycle the result is registered.
// A held result does not stop the next block from being taken; if the
// receiver still stalls when that block finishes, the block waits in the
// working registers and s_tready stays low until m_tready frees the
// output register.
`default_nettype none
module rc5_block_cipher_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [rc5_pkg::DATA_W-1:0]      s_tdata,  // word_a[31:0], word_b[63:32]
  input  wire logic                            s_tuser,  // opcode[0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [rc5_pkg::DATA_W-1:0]      m_tdata,  // out_a[31:0], out_b[63:32]
  input  wire logic                            cfg_we,
  input  wire logic [rc5_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rc5_pkg::CFG_W-1:0]       cfg_data
);
  import rc5_pkg::*;

  dp_cmd_t cmd;

  rc5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cmd      (cmd)
  );

  rc5_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

endmodule
`default_nettype wire
